/* hdl/sst_pkg.sv */
// Package for the sorted set table: sizes, command and status codes,
// the cell control struct and the order-key helper. No dependencies.
package sst_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int PW   = IDXW + 1;

  localparam int ELEM_W  = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 9;
  localparam int POS_MAX   = 255;
  localparam int COUNT_MAX = 511;

  typedef logic [VALUE_WIDTH-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic capture;  // latch compare flags against the key
    logic ins;      // open a slot at the boundary, shift larger entries up
    logic rem;      // close the gap, shift larger entries down
  } cell_ctl_t;

  // Sign-extend to 64 bits, keep VALUE_WIDTH bits, flip the sign bit so
  // that an unsigned compare gives the signed order.
  function automatic key_t make_key(input logic [ELEM_W-1:0] raw);
    logic [63:0] ext;
    key_t        k;
    ext = {{(64 - ELEM_W){raw[ELEM_W-1]}}, raw};
    k = ext[VALUE_WIDTH-1:0];
    k[VALUE_WIDTH-1] = ~k[VALUE_WIDTH-1];
    return k;
  endfunction

endpackage

/* hdl/sst_if.sv */
// Valid/ready channel interfaces of the sorted set table.
// Depends on sst_pkg for the payload widths.
interface sst_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [sst_pkg::ELEM_W-1:0] element;

  modport source (output valid, output command, output element, input ready);
  modport sink   (input valid, input command, input element, output ready);
endinterface

interface sst_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [sst_pkg::POS_W-1:0]     position;
  logic [sst_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output position, output count,
                  input ready);
  modport sink   (input valid, input status, input position, input count,
                  output ready);
endinterface

/* hdl/sst_cell.sv */
// One compare-and-shift cell of the sorted set row: holds one entry.
// Depends on sst_pkg.
module sst_cell (
  input  logic               clk,
  input  sst_pkg::cell_ctl_t ctl,
  input  sst_pkg::key_t      key,
  input  logic               cell_valid,
  input  logic               left_lt,
  input  sst_pkg::key_t      left_entry,
  input  sst_pkg::key_t      right_entry,
  output sst_pkg::key_t      entry,
  output logic               lt,
  output logic               eq
);

  sst_pkg::key_t entry_r, entry_nxt;
  logic          lt_r, eq_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !lt_r) begin
      entry_nxt = left_lt ? key : left_entry;
    end else if (ctl.rem && !lt_r) begin
      entry_nxt = right_entry;
    end
  end

  // Entry payload needs no reset: slots at or past the count are never read.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.capture) begin
      lt_r <= cell_valid && (entry_r < key);
      eq_r <= cell_valid && (entry_r == key);
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

/* hdl/sorted_set_table.sv */
// Sorted set table: distinct signed values kept ascending in a row of cells.
// Each item passes accept, compare and commit in turn; a new item is taken only
// once the last one has committed, and a result that waits to transfer holds
// the next item in commit until it drains.
// Reset (rst_n low, synchronous): empties the set and drops any pending result;
// entry contents are left as they are and are never read past the count.
module sorted_set_table (
  input  logic       clk,
  input  logic       rst_n,
  sst_in_if.sink     in_ch,
  sst_out_if.source  out_ch
);

  localparam int N = sst_pkg::CAPACITY;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_CMT} state_t;

  state_t                        state_r;
  sst_pkg::cmd_t                 cmd_r;
  sst_pkg::key_t                 key_r;
  logic [sst_pkg::CNTW-1:0]      count_r, count_nxt;
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [sst_pkg::POS_W-1:0]     out_pos_r;
  logic [sst_pkg::COUNT_W-1:0]   out_count_r;

  sst_pkg::key_t   entry_w [N];
  logic [N-1:0]    lt_w, eq_w, cell_valid_w, bnd_w;
  sst_pkg::cell_ctl_t ctl;

  logic                      found, any_bnd, commit, full;
  logic [sst_pkg::IDXW-1:0]  pos_idx;
  logic [sst_pkg::PW-1:0]    pos_w;
  sst_pkg::status_t          status_nxt;

  // Commit only when the output register is free or being drained.
  assign commit = (state_r == S_CMT) && (!out_valid_r || out_ch.ready);
  assign full   = (count_r >= sst_pkg::CNTW'(N));

  // ---------------------------------------------------------------------
  // Cell row: each cell compares its entry against the broadcast key and takes
  // the key or its left neighbor's entry on an insert, or its right neighbor's on a remove.
  // ---------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign cell_valid_w[g] = (sst_pkg::CNTW'(g) < count_r);
      sst_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .key         (key_r),
        .cell_valid  (cell_valid_w[g]),
        .left_lt     ((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g - 1]),
        .left_entry  ((g == 0) ? key_r : entry_w[(g == 0) ? 0 : g - 1]),
        .right_entry ((g == N - 1) ? entry_w[g] : entry_w[(g == N - 1) ? g : g + 1]),
        .entry       (entry_w[g]),
        .lt          (lt_w[g]),
        .eq          (eq_w[g])
      );
      // Boundary: first cell whose entry is not below the key.
      assign bnd_w[g] = ((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g - 1]) && !lt_w[g];
    end
  endgenerate

  // Encode the one-hot boundary; with no boundary every slot is below the
  // key and the store is full, so the position is the capacity.
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (bnd_w[i]) pos_idx = pos_idx | sst_pkg::IDXW'(i);
    end
  end

  assign any_bnd = |bnd_w;
  assign found   = |eq_w;
  assign pos_w   = any_bnd ? {1'b0, pos_idx} : sst_pkg::PW'(N);

  // Commit decisions: insert opens a slot only for a new value with room,
  // remove closes one only for a present value.
  always_comb begin
    ctl         = '0;
    ctl.capture = (state_r == S_CMP);
    count_nxt   = count_r;
    status_nxt  = sst_pkg::ST_DONE;
    case (cmd_r)
      sst_pkg::CMD_INSERT: begin
        if (found) begin
          status_nxt = sst_pkg::ST_MISS;
        end else if (full) begin
          status_nxt = sst_pkg::ST_FULL;
        end else begin
          ctl.ins   = commit;
          count_nxt = count_r + 1'b1;
        end
      end
      sst_pkg::CMD_REMOVE: begin
        if (found) begin
          ctl.rem   = commit;
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = sst_pkg::ST_MISS;
        end
      end
      sst_pkg::CMD_LOOKUP: begin
        status_nxt = found ? sst_pkg::ST_DONE : sst_pkg::ST_MISS;
      end
      sst_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = sst_pkg::ST_DONE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: accept, compare, commit; hold in commit while the previous
  // result waits to transfer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result on commit, otherwise drop valid once it transfers.
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= sst_pkg::cmd_t'(in_ch.command);
            key_r   <= sst_pkg::make_key(in_ch.element);
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_CMT;
        end
        S_CMT: begin
          if (commit) begin
            count_r      <= count_nxt;
            out_status_r <= status_nxt;
            if (cmd_r == sst_pkg::CMD_CLEAR) begin
              out_pos_r <= '0;
            end else if (int'(pos_w) > sst_pkg::POS_MAX) begin
              out_pos_r <= sst_pkg::POS_W'(sst_pkg::POS_MAX);
            end else begin
              out_pos_r <= sst_pkg::POS_W'(pos_w);
            end
            if (int'(count_nxt) > sst_pkg::COUNT_MAX) begin
              out_count_r <= sst_pkg::COUNT_W'(sst_pkg::COUNT_MAX);
            end else begin
              out_count_r <= sst_pkg::COUNT_W'(count_nxt);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.count    = out_count_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_set_table: drives insert, remove, lookup and
// clear commands and checks every result against a local sorted-set tracker.
// Depends on sst_pkg and the channel interfaces sst_in_if / sst_out_if.
module tb_top;
  import sst_pkg::*;

  typedef struct {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } answer_t;

  logic clk;
  logic rst_n;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sorted_set_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Tracked contents of the table: ascending, distinct, set_size valid.
  logic signed [VALUE_WIDTH-1:0] held_vals [CAPACITY];
  int                            set_size;
  int                            peak_size;

  answer_t pending_answers [$];

  bit idle_enable;
  int ready_hold;
  int sent_by_cmd [4];
  int results_checked;
  int full_refusals;
  int errors;

  // Clock: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: stop a hung run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending_answers.size());
    $display("FAIL sorted_set_table");
    $finish;
  end

  // Apply one command to the tracked set and return the result it must give.
  // Only entries below set_size are ever looked at.
  function automatic answer_t apply_set_command(input cmd_t cmd,
                                                input logic signed [ELEM_W-1:0] elem);
    answer_t                       a;
    logic signed [VALUE_WIDTH-1:0] v;
    int                            slot;
    bit                            hit;
    v = elem;  // sign-extend or trim to the stored width
    if (cmd == CMD_CLEAR) begin
      set_size = 0;
      a.status = ST_DONE;
      a.position = '0;
      a.count = '0;
      return a;
    end
    slot = 0;
    while (slot < set_size && held_vals[slot] < v) slot++;
    hit = (slot < set_size) && (held_vals[slot] == v);
    case (cmd)
      CMD_INSERT: begin
        // Duplicate wins over full.
        if (hit) begin
          a.status = ST_MISS;
        end else if (set_size >= CAPACITY) begin
          a.status = ST_FULL;
        end else begin
          for (int j = set_size; j > slot; j--) held_vals[j] = held_vals[j-1];
          held_vals[slot] = v;
          set_size++;
          a.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          for (int j = slot; j < set_size - 1; j++) held_vals[j] = held_vals[j+1];
          set_size--;
          a.status = ST_DONE;
        end else begin
          a.status = ST_MISS;
        end
      end
      default: a.status = hit ? ST_DONE : ST_MISS;
    endcase
    a.position = POS_W'((slot > POS_MAX) ? POS_MAX : slot);
    a.count = COUNT_W'((set_size > COUNT_MAX) ? COUNT_MAX : set_size);
    return a;
  endfunction

  // Pick a value: often one held in the set or right next to one, otherwise
  // small values, the extremes, or anything at all.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    logic signed [ELEM_W-1:0] e;
    int                       roll;
    roll = $urandom_range(0, 99);
    if (set_size > 0 && roll < 45) begin
      e = held_vals[$urandom_range(0, set_size - 1)];
    end else if (set_size > 0 && roll < 55) begin
      e = held_vals[$urandom_range(0, set_size - 1)];
      e = ($urandom_range(0, 1) != 0) ? e + 1 : e - 1;
    end else if (roll < 75) begin
      e = $signed($urandom_range(0, 40)) - 20;
    end else if (roll < 80) begin
      e = ($urandom_range(0, 1) != 0) ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
    end else begin
      e = $urandom;
    end
    return e;
  endfunction

  // Send one item and record its expected result at the transfer edge.
  // Valid is left high so back-to-back items need no second assignment.
  task automatic send_item(input cmd_t cmd, input logic signed [ELEM_W-1:0] elem);
    bit took;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.element <= elem;
    // Sample ready mid-cycle; the transfer happens at the following edge.
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    pending_answers.push_back(apply_set_command(cmd, elem));
    sent_by_cmd[cmd]++;
    if (set_size > peak_size) peak_size = set_size;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_for_answers();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Result side: stall ready in random bursts while idling is on.
  initial begin
    out_ch.ready <= 1'b0;
    ready_hold = 0;
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker: sample mid-cycle, compare against the oldest expectation.
  always @(negedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: status %0d pos %0d count %0d", $realtime,
                   out_ch.status, out_ch.position, out_ch.count);
      end else begin
        want = pending_answers.pop_front();
        if (want.status == ST_FULL) full_refusals++;
        if (out_ch.status !== want.status || out_ch.position !== want.position ||
            out_ch.count !== want.count) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] result %0d: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                     $realtime, results_checked, want.status, want.position, want.count,
                     out_ch.status, out_ch.position, out_ch.count);
        end
      end
    end
  end

  // Empty-table cases, both extremes, duplicates, misses and clears.
  task automatic test_directed();
    send_item(CMD_LOOKUP, 0);
    send_item(CMD_REMOVE, 5);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 1);
    send_item(CMD_INSERT, 0);
    send_item(CMD_LOOKUP, 32'sh8000_0000);
    send_item(CMD_LOOKUP, 32'sh7fff_ffff);
    send_item(CMD_LOOKUP, 2);
    send_item(CMD_REMOVE, -1);
    send_item(CMD_REMOVE, -1);
    send_item(CMD_REMOVE, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 32'sh5555_5555);
    send_item(CMD_INSERT, 32'shaaaa_aaaa);
    // Clear ignores its element: give it a nonzero one.
    send_item(CMD_CLEAR, 32'sh1234_5678);
    send_item(CMD_LOOKUP, 0);
    send_item(CMD_INSERT, 7);
    send_item(CMD_CLEAR, 0);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
  endtask

  // Mixed traffic, mostly on values that hit or just miss the held set.
  task automatic test_random_mix(input int n);
    int   roll;
    cmd_t cmd;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 2)       cmd = CMD_CLEAR;
      else if (roll < 45) cmd = CMD_INSERT;
      else if (roll < 72) cmd = CMD_REMOVE;
      else                cmd = CMD_LOOKUP;
      send_item(cmd, pick_element());
    end
  endtask

  // Fill the table to capacity, then exercise the full refusal paths.
  task automatic test_fill_to_full();
    logic signed [ELEM_W-1:0] e;
    wait_for_answers();
    send_item(CMD_CLEAR, $urandom);
    while (set_size < CAPACITY) begin
      if ($urandom_range(0, 7) == 0) begin
        send_item(CMD_LOOKUP, pick_element());
      end else begin
        e = $urandom;
        // Keep the top value free so it can be refused at the end position.
        if (e == 32'sh7fff_ffff) e = 0;
        send_item(CMD_INSERT, e);
      end
    end
    send_item(CMD_INSERT, 32'sh7fff_ffff);  // refused, position saturates
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, held_vals[$urandom_range(0, CAPACITY - 1)]);  // duplicate
    send_item(CMD_LOOKUP, held_vals[CAPACITY-1]);
    send_item(CMD_LOOKUP, held_vals[0]);
    repeat (8) send_item(CMD_INSERT, $urandom);
    send_item(CMD_REMOVE, held_vals[CAPACITY-1]);
    send_item(CMD_INSERT, 32'sh7fff_ffff);  // takes the last slot
    send_item(CMD_LOOKUP, 32'sh7fff_ffff);
    send_item(CMD_INSERT, pick_element());
    send_item(CMD_REMOVE, held_vals[$urandom_range(0, CAPACITY - 1)]);
    send_item(CMD_INSERT, $urandom);
  endtask

  // Empty the table again, mostly by removing held values.
  task automatic test_drain();
    int roll;
    wait_for_answers();
    while (set_size > 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      send_item(CMD_REMOVE, held_vals[$urandom_range(0, set_size - 1)]);
      else if (roll < 80) send_item(CMD_REMOVE, $urandom);
      else                send_item(CMD_LOOKUP, pick_element());
    end
    send_item(CMD_LOOKUP, pick_element());
    send_item(CMD_REMOVE, pick_element());
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_INSERT;
    in_ch.element <= '0;
    set_size = 0;
    peak_size = 0;
    results_checked = 0;
    full_refusals = 0;
    errors = 0;
    idle_enable = 1'b1;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;

    // Hold reset low, then release it at an edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(350);
    test_fill_to_full();
    test_drain();
    // Last stretch back to back with no stalls on either side.
    wait_for_answers();
    idle_enable = 1'b0;
    test_random_mix(120);

    wait_for_answers();
    repeat (10) @(posedge clk);

    $display("Sent %0d inserts, %0d removes, %0d lookups, %0d clears; table peaked at %0d of %0d",
             sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_REMOVE], sent_by_cmd[CMD_LOOKUP],
             sent_by_cmd[CMD_CLEAR], peak_size, CAPACITY);
    $display("Checked %0d results (%0d full refusals), %0d mismatches",
             results_checked, full_refusals, errors);
    if (errors == 0) begin
      $display("PASS sorted_set_table");
    end else begin
      $display("FAIL sorted_set_table");
    end
    $finish;
  end

endmodule
